[hw/rtl/fec_wt_pkg.sv]
`default_nettype none
// ============================================================================
// fec_wt_pkg: shared types and constants of the FEC block window tracker
// Status codes, controller state codes, command and status bundles, and the
// fixed widths of the divider used for slot index and skip count.
// ============================================================================
package fec_wt_pkg;

    // Fixed field widths of the request and result.
    localparam int BLOCK_W   = 31;
    localparam int SYM_W     = 5;
    localparam int HELD_W    = 6;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 5;

    // Window register value after reset.
    localparam logic [CFG_W-1:0] WIN_RESET = 5'd16;

    // Counter value at which the counter restarts from zero.
    localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

    // Divider: 32-bit dividend, two quotient bits per clock.
    localparam int DIV_W      = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_ITERS  = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_STALE   = 3'd2,
        ST_DUP     = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    // Controller states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DIV_SLOT = 6'b000010,
        S_READ     = 6'b000100,
        S_EVAL     = 6'b001000,
        S_DIV_SKIP = 6'b010000,
        S_FINISH   = 6'b100000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request, start the slot division
        logic read;        // read the addressed slot
        logic skip_start;  // start the skip-count division
        logic finish;      // update the slot and counters, present the result
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;    // divider result is ready
        logic skip_need;   // the takeover skips blocks beyond the window
    } t_ctrl_stat;

endpackage
`default_nettype wire

[hw/rtl/fec_receive_block_window_tracker_core.sv]
`default_nettype none
// ============================================================================
// fec_receive_block_window_tracker_core: FEC receive block window tracker
// Records which source symbols of each FEC block have arrived in a window of
// block slots, and counts flushed and skipped blocks.
// ============================================================================
// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. Each request gives exactly one result, shown for a
// single cycle with o_done high; the receiver cannot stall it, so it must take
// the result in that cycle. busy drops together with o_done, so a new request
// can be taken at the edge that ends the o_done cycle, but not while one is in
// work. The time taken is set mainly by the shared iterative divider, which
// produces two quotient bits per clock and runs once for the slot index (block
// number modulo the window) and, when a block takeover skips blocks beyond the
// window, once more for the skipped-block count, so such a request takes longer.
// The window register may be written only while busy is low and no result is
// pending.
module fec_receive_block_window_tracker_core #(
    parameter int SLOTS             = 16,
    parameter int SYMBOLS_PER_BLOCK = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_action,
    input  wire logic [fec_wt_pkg::BLOCK_W-1:0]    i_block_num,
    input  wire logic [fec_wt_pkg::SYM_W-1:0]      i_symbol_index,
    output logic                                   o_done,
    output logic [2:0]                             o_status,
    output logic [fec_wt_pkg::HELD_W-1:0]          o_symbols_held,
    output logic [fec_wt_pkg::CNT_W-1:0]           o_flushed_blocks,
    output logic [fec_wt_pkg::CNT_W-1:0]           o_ignored_blocks,
    input  wire logic                              i_cfg_we,
    input  wire logic [fec_wt_pkg::CFG_W-1:0]      i_cfg_wdata
);

    fec_wt_pkg::t_ctrl_cmd  cmd;
    fec_wt_pkg::t_ctrl_stat stat;

    // Sequencing controller.
    fec_wt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // Slot storage, divider and counters.
    fec_wt_dp #(
        .SLOTS             (SLOTS),
        .SYMBOLS_PER_BLOCK (SYMBOLS_PER_BLOCK)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_action),
        .i_block_num      (i_block_num),
        .i_symbol_index   (i_symbol_index),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_symbols_held   (o_symbols_held),
        .o_flushed_blocks (o_flushed_blocks),
        .o_ignored_blocks (o_ignored_blocks)
    );

endmodule
`default_nettype wire

[hw/rtl/fec_wt_div.sv]
`default_nettype none
// ============================================================================
// fec_wt_div: iterative unsigned divider
// Restoring division of a 32-bit dividend by a narrow divisor, two quotient
// bits per clock. Pulses o_done once the last step is registered, with the result.
// ============================================================================
module fec_wt_div #(
    parameter int DW = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fec_wt_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [DW-1:0]                 i_divisor,
    output logic                               o_done,
    output logic [fec_wt_pkg::DIV_W-1:0]       o_quotient,
    output logic [DW-1:0]                      o_remainder
);

    logic                                r_busy;
    logic                                r_done;
    logic [fec_wt_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [DW-1:0]                       r_div;
    logic [DW-1:0]                       r_rem;
    logic [fec_wt_pkg::DIV_W-1:0]        r_quo;
    logic [DW-1:0]                       n_rem;
    logic [fec_wt_pkg::DIV_W-1:0]        n_quo;

    // Two restoring steps: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        qbit;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < fec_wt_pkg::DIV_STEPS; k++) begin
            trial = {n_rem, n_quo[fec_wt_pkg::DIV_W-1]};
            diff  = trial - {1'b0, r_div};
            qbit  = (trial >= {1'b0, r_div});
            n_rem = qbit ? diff[DW-1:0] : trial[DW-1:0];
            n_quo = {n_quo[fec_wt_pkg::DIV_W-2:0], qbit};
        end
    end

    // Control: iteration counter, busy and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fec_wt_pkg::DIV_CNT_W'(fec_wt_pkg::DIV_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

[hw/rtl/fec_wt_ctrl.sv]
`default_nettype none
// ============================================================================
// fec_wt_ctrl: sequencing controller of the FEC block window tracker
// Steps one request through slot division, slot read, evaluation, the
// optional skip division and the final update.
// ============================================================================
module fec_wt_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire fec_wt_pkg::t_ctrl_stat i_stat,
    output logic                        o_busy,
    output fec_wt_pkg::t_ctrl_cmd       o_cmd
);

    fec_wt_pkg::t_state r_state;
    fec_wt_pkg::t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            fec_wt_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = fec_wt_pkg::S_DIV_SLOT;
                end
            end
            fec_wt_pkg::S_DIV_SLOT: begin
                if (i_stat.div_done) begin
                    n_state = fec_wt_pkg::S_READ;
                end
            end
            fec_wt_pkg::S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = fec_wt_pkg::S_EVAL;
            end
            fec_wt_pkg::S_EVAL: begin
                if (i_stat.skip_need) begin
                    o_cmd.skip_start = 1'b1;
                    n_state          = fec_wt_pkg::S_DIV_SKIP;
                end else begin
                    n_state = fec_wt_pkg::S_FINISH;
                end
            end
            fec_wt_pkg::S_DIV_SKIP: begin
                if (i_stat.div_done) begin
                    n_state = fec_wt_pkg::S_FINISH;
                end
            end
            fec_wt_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = fec_wt_pkg::S_IDLE;
            end
            default: begin
                n_state = fec_wt_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fec_wt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != fec_wt_pkg::S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/fec_wt_dp.sv]
`default_nettype none
// ============================================================================
// fec_wt_dp: datapath of the FEC block window tracker
// Window register, slot memory with occupancy flags, the shared divider,
// slot evaluation, flushed and ignored counters, and the result registers.
// ============================================================================
module fec_wt_dp #(
    parameter int SLOTS             = 16,
    parameter int SYMBOLS_PER_BLOCK = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fec_wt_pkg::t_ctrl_cmd             i_cmd,
    output fec_wt_pkg::t_ctrl_stat                 o_stat,
    input  wire logic                              i_cfg_we,
    input  wire logic [fec_wt_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                              i_action,
    input  wire logic [fec_wt_pkg::BLOCK_W-1:0]    i_block_num,
    input  wire logic [fec_wt_pkg::SYM_W-1:0]      i_symbol_index,
    output logic                                   o_done,
    output logic [2:0]                             o_status,
    output logic [fec_wt_pkg::HELD_W-1:0]          o_symbols_held,
    output logic [fec_wt_pkg::CNT_W-1:0]           o_flushed_blocks,
    output logic [fec_wt_pkg::CNT_W-1:0]           o_ignored_blocks
);

    localparam int WIN_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MASK_W = SYMBOLS_PER_BLOCK;
    localparam int SCNT_W = $clog2(SYMBOLS_PER_BLOCK + 1);

    // Configuration and request registers.
    logic [fec_wt_pkg::CFG_W-1:0]    r_win;
    logic                            r_act;
    logic [fec_wt_pkg::BLOCK_W-1:0]  r_blk;
    logic [fec_wt_pkg::SYM_W-1:0]    r_sym;
    logic [WIN_W-1:0]                win_eff;

    // Slot storage.
    logic [fec_wt_pkg::BLOCK_W-1:0]  r_mem_block [SLOTS];
    logic [SCNT_W-1:0]               r_mem_cnt   [SLOTS];
    logic [MASK_W-1:0]               r_mem_mask  [SLOTS];
    logic [SLOTS-1:0]                r_occ;

    // Registered read of the addressed slot.
    logic [SLOT_W-1:0]               r_slot;
    logic                            r_rd_occ;
    logic [fec_wt_pkg::BLOCK_W-1:0]  r_rd_block;
    logic [SCNT_W-1:0]               r_rd_cnt;
    logic [MASK_W-1:0]               r_rd_mask;

    // Divider connections.
    logic                            div_start;
    logic [fec_wt_pkg::DIV_W-1:0]    div_dividend;
    logic                            div_done;
    logic [fec_wt_pkg::DIV_W-1:0]    div_quo;
    logic [WIN_W-1:0]                div_rem;
    logic [SLOT_W-1:0]               rem_slot;

    // Evaluation of the slot against the request.
    logic [fec_wt_pkg::BLOCK_W-1:0]  rd_block;
    logic [SCNT_W-1:0]               rd_cnt;
    logic [MASK_W-1:0]               rd_mask;
    logic                            takeover;
    logic                            flush;
    logic                            same_blk;
    logic [fec_wt_pkg::BLOCK_W-1:0]  blk_diff;
    logic                            skip_need;

    // Final update.
    logic [SCNT_W-1:0]               base_cnt;
    logic [MASK_W-1:0]               base_mask;
    logic [MASK_W-1:0]               sym_bit;
    logic                            sym_ok;
    logic                            dup;
    fec_wt_pkg::t_status             n_status;
    logic [SCNT_W-1:0]               n_cnt;
    logic [MASK_W-1:0]               n_mask;
    logic [SCNT_W-1:0]               n_held;
    logic                            n_wr;
    logic [fec_wt_pkg::CNT_W-1:0]    flush_base;
    logic [fec_wt_pkg::CNT_W-1:0]    skip_base;

    // Result registers.
    logic                            r_done;
    fec_wt_pkg::t_status             r_status;
    logic [SCNT_W-1:0]               r_held;
    logic [fec_wt_pkg::CNT_W-1:0]    r_flush;
    logic [fec_wt_pkg::CNT_W-1:0]    r_skip;

    // Window register; a value of zero acts as one, values past SLOTS as SLOTS.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= fec_wt_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_win == '0) begin
            win_eff = WIN_W'(1);
        end else if (int'(r_win) > SLOTS) begin
            win_eff = WIN_W'(SLOTS);
        end else begin
            win_eff = WIN_W'(r_win);
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_blk <= i_block_num;
            r_sym <= i_symbol_index;
        end
    end

    // The shared divider computes the slot index first, then the skip count.
    assign div_start    = i_cmd.load | i_cmd.skip_start;
    assign div_dividend = i_cmd.load ? {1'b0, i_block_num} : {1'b0, blk_diff};
    assign rem_slot     = div_rem[SLOT_W-1:0];

    fec_wt_div #(
        .DW (WIN_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (win_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Slot read, registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_slot     <= rem_slot;
            r_rd_occ   <= r_occ[rem_slot];
            r_rd_block <= r_mem_block[rem_slot];
            r_rd_cnt   <= r_mem_cnt[rem_slot];
            r_rd_mask  <= r_mem_mask[rem_slot];
        end
    end

    // An empty slot reads as all zero.
    assign rd_block = r_rd_occ ? r_rd_block : '0;
    assign rd_cnt   = r_rd_occ ? r_rd_cnt   : '0;
    assign rd_mask  = r_rd_occ ? r_rd_mask  : '0;

    // A symbol of a newer block, or any symbol for an empty slot, takes over.
    assign takeover  = !r_act && (!r_rd_occ || (r_blk > rd_block));
    assign flush     = takeover && r_rd_occ && (rd_cnt != '0);
    assign same_blk  = r_rd_occ && (r_blk == rd_block);
    assign blk_diff  = r_blk - rd_block;
    assign skip_need = flush && (blk_diff > fec_wt_pkg::BLOCK_W'(win_eff));

    assign o_stat.div_done  = div_done;
    assign o_stat.skip_need = skip_need;

    // Symbol handling after a possible takeover.
    assign base_cnt  = takeover ? '0 : rd_cnt;
    assign base_mask = takeover ? '0 : rd_mask;
    assign sym_bit   = MASK_W'(1) << r_sym;
    assign sym_ok    = ({1'b0, r_sym} < (fec_wt_pkg::SYM_W + 1)'(SYMBOLS_PER_BLOCK));
    assign dup       = !sym_ok || ((base_mask & sym_bit) != '0);

    always_comb begin
        n_status = fec_wt_pkg::ST_STORED;
        n_cnt    = base_cnt;
        n_mask   = base_mask;
        n_held   = base_cnt;
        n_wr     = 1'b0;
        if (r_act) begin
            n_status = fec_wt_pkg::ST_CLEARED;
            n_cnt    = '0;
            n_mask   = '0;
            n_held   = '0;
            n_wr     = 1'b1;
        end else if (takeover || (same_blk && (rd_cnt != '0))) begin
            if (dup) begin
                // Nothing stored, but a takeover still empties the slot.
                n_status = fec_wt_pkg::ST_DUP;
                n_wr     = takeover;
            end else begin
                n_status = fec_wt_pkg::ST_STORED;
                n_mask   = base_mask | sym_bit;
                n_cnt    = base_cnt + 1'b1;
                n_held   = base_cnt + 1'b1;
                n_wr     = 1'b1;
            end
        end else if (!same_blk) begin
            n_status = fec_wt_pkg::ST_STALE;
            n_held   = rd_cnt;
        end else begin
            // Block was cleared earlier: its symbols are ignored.
            n_status = fec_wt_pkg::ST_CLOSED;
            n_held   = '0;
        end
    end

    // Slot memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (n_wr) begin
                r_mem_cnt[r_slot]  <= n_cnt;
                r_mem_mask[r_slot] <= n_mask;
            end
            if (takeover) begin
                r_mem_block[r_slot] <= r_blk;
            end
        end
    end

    // Occupancy flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.finish && takeover) begin
            r_occ[r_slot] <= 1'b1;
        end
    end

    // A counter at its maximum restarts from zero before the update.
    assign flush_base = (r_flush == fec_wt_pkg::CNT_MAX) ? '0 : r_flush;
    assign skip_base  = (r_skip  == fec_wt_pkg::CNT_MAX) ? '0 : r_skip;

    // Counters and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= '0;
            r_skip  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish && flush) begin
                r_flush <= flush_base + 1'b1;
            end
            if (i_cmd.finish && skip_need) begin
                r_skip <= skip_base + div_quo - 1'b1;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_held   <= n_held;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_symbols_held   = fec_wt_pkg::HELD_W'(r_held);
    assign o_flushed_blocks = r_flush;
    assign o_ignored_blocks = r_skip;

endmodule
`default_nettype wire

[hw/rtl/fec_wt_checker.sv]
`default_nettype none
// ============================================================================
// fec_wt_checker: port-level checks of the FEC block window tracker
// Watches the request and result ports over time; bound to the top level.
// ============================================================================
module fec_wt_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              o_done,
    input  wire logic [2:0]                        o_status,
    input  wire logic [fec_wt_pkg::HELD_W-1:0]     o_symbols_held,
    input  wire logic [fec_wt_pkg::CNT_W-1:0]      o_flushed_blocks
);

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but busy not raised");

    // The result comes out as busy drops, never while a request is in work.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // One request gives one single-cycle result.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A cleared slot reports no symbols held.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == fec_wt_pkg::ST_CLEARED)) |-> (o_symbols_held == '0))
        else $error("cleared result with symbols held");

    // The flushed counter moves only together with a result.
    a_flush_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_flushed_blocks) |-> o_done)
        else $error("flushed counter changed without a result");

endmodule

bind fec_receive_block_window_tracker_core fec_wt_checker u_fec_wt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_status         (o_status),
    .o_symbols_held   (o_symbols_held),
    .o_flushed_blocks (o_flushed_blocks)
);
`default_nettype wire

[verif/fec_receive_block_window_tracker_core_test.sv]
// ============================================================================
// fec_receive_block_window_tracker_core_test: self-checking bench for the
// FEC receive block window tracker
// A clocked driver feeds symbol and clear requests and window writes from a
// queue. A clocked monitor compares every result against a tracker model
// kept in the bench. The stimulus walks the window corner cases, random
// traffic over several window settings, and a run of block skips that drives
// the ignored-block counter to its maximum and past it.
// ============================================================================
module fec_receive_block_window_tracker_core_test;

    localparam int TRACK_SLOTS   = 16;
    localparam int TRACK_SYMBOLS = 32;
    localparam logic [30:0] TOP_BLOCK = 31'h7FFF_FFFF;

    // One queued operation: either a request or a window register write.
    typedef struct packed {
        logic        is_window_write;
        logic [4:0]  window_value;
        logic        action;
        logic [30:0] block_num;
        logic [4:0]  symbol_index;
    } t_tracker_op;

    // One result as the block reports it.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  held;
        logic [31:0] flushed;
        logic [31:0] ignored;
    } t_tracker_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_action = 1'b0;
    logic [30:0] i_block_num = '0;
    logic [4:0]  i_symbol_index = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [5:0]  o_symbols_held;
    logic [31:0] o_flushed_blocks;
    logic [31:0] o_ignored_blocks;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;

    // Tracker model state.
    logic [30:0] held_block [TRACK_SLOTS];
    logic        held_valid [TRACK_SLOTS];
    logic [5:0]  held_count [TRACK_SLOTS];
    logic [31:0] held_mask  [TRACK_SLOTS];
    logic [31:0] flushed_total = '0;
    logic [31:0] ignored_total = '0;
    logic [4:0]  window_reg = fec_wt_pkg::WIN_RESET;

    t_tracker_op     symbol_requests [$];
    t_tracker_report expected_reports [$];

    int in_flight = 0;
    int requests_sent = 0;
    int window_writes = 0;
    int gap_left = 0;
    int mismatches = 0;
    int reports_checked = 0;
    int status_tally [5];
    bit ignored_wrapped = 0;

    fec_receive_block_window_tracker_core #(
        .SLOTS             (TRACK_SLOTS),
        .SYMBOLS_PER_BLOCK (TRACK_SYMBOLS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_block_num      (i_block_num),
        .i_symbol_index   (i_symbol_index),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_symbols_held   (o_symbols_held),
        .o_flushed_blocks (o_flushed_blocks),
        .o_ignored_blocks (o_ignored_blocks),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    initial begin
        for (int i = 0; i < TRACK_SLOTS; i++) begin
            held_block[i] = '0;
            held_valid[i] = 1'b0;
            held_count[i] = '0;
            held_mask[i]  = '0;
        end
        for (int i = 0; i < 5; i++) status_tally[i] = 0;
    end

    // The window register is clamped to 1..SLOTS before use.
    function automatic int unsigned clamp_window(input logic [4:0] value);
        if (value == 0) return 1;
        if (value > TRACK_SLOTS) return TRACK_SLOTS;
        return value;
    endfunction

    // Applies one request to the tracker model and returns its report.
    function automatic t_tracker_report track_symbol(input logic act,
                                                     input logic [30:0] blk,
                                                     input logic [4:0] sym);
        t_tracker_report rep;
        int unsigned w;
        int unsigned slot;
        logic [31:0] gap;
        w = clamp_window(window_reg);
        slot = blk % w;
        if (act) begin
            held_count[slot] = '0;
            held_mask[slot] = '0;
            rep.status = fec_wt_pkg::ST_CLEARED;
        end else if (!held_valid[slot] || blk > held_block[slot]) begin
            // A newer block takes the slot; a non-empty old block is flushed.
            if (held_valid[slot] && held_count[slot] != 0) begin
                gap = {1'b0, blk} - {1'b0, held_block[slot]};
                if (flushed_total == fec_wt_pkg::CNT_MAX) flushed_total = '0;
                flushed_total = flushed_total + 1;
                if (gap > w) begin
                    if (ignored_total == fec_wt_pkg::CNT_MAX) ignored_total = '0;
                    ignored_total = ignored_total + gap / w - 1;
                end
            end
            held_count[slot] = '0;
            held_mask[slot] = '0;
            held_block[slot] = blk;
            held_valid[slot] = 1'b1;
            rep.status = fec_wt_pkg::ST_STORED;
        end else if (blk != held_block[slot]) begin
            rep.status = fec_wt_pkg::ST_STALE;
        end else if (held_count[slot] == 0) begin
            rep.status = fec_wt_pkg::ST_CLOSED;
        end else begin
            rep.status = fec_wt_pkg::ST_STORED;
        end
        // Record the symbol unless it was seen already.
        if (!act && rep.status == fec_wt_pkg::ST_STORED) begin
            if (held_mask[slot][sym]) begin
                rep.status = fec_wt_pkg::ST_DUP;
            end else begin
                held_mask[slot][sym] = 1'b1;
                held_count[slot] = held_count[slot] + 6'd1;
            end
        end
        rep.held = held_count[slot];
        rep.flushed = flushed_total;
        rep.ignored = ignored_total;
        return rep;
    endfunction

    task automatic queue_request(input logic act, input logic [30:0] blk,
                                 input logic [4:0] sym);
        t_tracker_op op;
        op = '0;
        op.action = act;
        op.block_num = blk;
        op.symbol_index = sym;
        symbol_requests.push_back(op);
    endtask

    task automatic queue_window(input logic [4:0] value);
        t_tracker_op op;
        op = '0;
        op.is_window_write = 1'b1;
        op.window_value = value;
        symbol_requests.push_back(op);
    endtask

    // Returns once everything queued has been sent and answered.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (symbol_requests.size() != 0 || start || i_cfg_we ||
               expected_reports.size() != 0);
    endtask

    // Request driver: holds start until the request is taken, then predicts
    // its report. Window writes go out only with nothing in flight.
    always @(posedge i_clk) begin : request_driver
        t_tracker_op head;
        logic raise;
        logic write_now;
        raise = start;
        write_now = 1'b0;
        if (i_cfg_we) window_reg = i_cfg_wdata;
        if (i_rst_n) begin
            if (o_done) in_flight--;
            if (start && !busy) begin
                expected_reports.push_back(track_symbol(i_action, i_block_num,
                                                        i_symbol_index));
                in_flight++;
                requests_sent++;
                raise = 1'b0;
                // Random hold-off, except in one long stretch of full rate.
                if ((requests_sent < 300 || requests_sent >= 550) &&
                    $urandom_range(0, 99) < 15) begin
                    gap_left = $urandom_range(1, 40);
                end
            end
            if (!raise && symbol_requests.size() != 0) begin
                head = symbol_requests[0];
                if (head.is_window_write) begin
                    if (in_flight == 0 && !busy && !i_cfg_we) begin
                        write_now = 1'b1;
                        i_cfg_wdata <= head.window_value;
                        void'(symbol_requests.pop_front());
                        window_writes++;
                    end
                end else if (gap_left != 0) begin
                    // The hold-off only counts cycles in which the block is idle.
                    if (!busy) gap_left--;
                end else begin
                    raise = 1'b1;
                    i_action <= head.action;
                    i_block_num <= head.block_num;
                    i_symbol_index <= head.symbol_index;
                    void'(symbol_requests.pop_front());
                end
            end
        end
        start <= raise;
        i_cfg_we <= write_now;
    end

    // Result monitor: every strobed result must match the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_tracker_report want;
        t_tracker_report got;
        got = {o_status, o_symbols_held, o_flushed_blocks, o_ignored_blocks};
        if (i_rst_n && o_done) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result with no request outstanding: status %0d held %0d",
                         $time, got.status, got.held);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (want.status <= fec_wt_pkg::ST_CLEARED) status_tally[want.status]++;
                if (got !== want) begin
                    $display("%0t: expected status %0d held %0d flushed %0d ignored %0d",
                             $time, want.status, want.held, want.flushed, want.ignored);
                    $display("%0t: actual   status %0d held %0d flushed %0d ignored %0d",
                             $time, got.status, got.held, got.flushed, got.ignored);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed cases, random phases, then counter saturation.
    initial begin : stimulus
        logic [4:0] phase_windows [9];
        logic [30:0] base;
        logic [30:0] first_blk;
        int unsigned w;
        int unsigned slot;
        int unsigned roll;
        longint unsigned room;
        longint unsigned steps;
        bit wrap_next;

        phase_windows = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd9, 5'd16, 5'd0};
        phase_windows[8] = 5'($urandom_range(1, 16));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: store, duplicate, takeover, stale, clear, closed block.
        queue_request(1'b0, 31'd0, 5'd0);
        queue_request(1'b0, 31'd0, 5'd31);
        queue_request(1'b0, 31'd0, 5'd31);
        queue_request(1'b0, 31'd16, 5'd5);
        queue_request(1'b0, 31'd0, 5'd1);
        queue_request(1'b0, 31'd96, 5'd2);
        queue_request(1'b1, 31'd96, 5'd0);
        queue_request(1'b0, 31'd96, 5'd3);
        queue_request(1'b0, 31'd112, 5'd4);
        // Clear of a slot that never held a block, then its first symbol.
        queue_request(1'b1, 31'd5, 5'd31);
        queue_request(1'b0, 31'd5, 5'd7);
        // A window of zero acts as one.
        queue_window(5'd0);
        queue_request(1'b0, 31'd113, 5'd0);
        queue_request(1'b0, 31'd200, 5'd0);
        // A window above the slot count acts as the slot count.
        queue_window(5'd31);
        queue_request(1'b0, 31'd207, 5'd9);
        queue_request(1'b0, 31'd239, 5'd10);
        queue_request(1'b0, 31'd207, 5'd9);
        wait_drained();

        // Random phases: mostly traffic inside a slowly moving window.
        base = 31'd1000;
        for (int p = 0; p < 9; p++) begin
            queue_window(phase_windows[p]);
            w = clamp_window(phase_windows[p]);
            for (int n = 0; n < 135; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    queue_request(1'b1, 31'(base + $urandom_range(0, 2 * w - 1)),
                                  5'($urandom));
                end else if (roll < 14) begin
                    queue_request(1'b0, 31'(base - $urandom_range(1, 3 * w)),
                                  5'($urandom));
                end else if (roll < 18) begin
                    base = 31'(base + $urandom_range(w, 40 * w));
                    queue_request(1'b0, base, 5'($urandom));
                end else if (roll < 21) begin
                    queue_request(1'($urandom), 31'($urandom_range(0, base + 64)),
                                  5'($urandom));
                end else begin
                    queue_request(1'b0, 31'(base + $urandom_range(0, w - 1)),
                                  5'($urandom));
                end
                if ($urandom_range(0, 47) == 0) base = base + 31'd1;
            end
            wait_drained();
        end

        // Drive the ignored-block counter to its maximum with long skips,
        // one window setting per slot, then skip once more past it.
        wrap_next = 0;
        for (w = 1; w <= TRACK_SLOTS && !ignored_wrapped; w++) begin
            slot = w - 1;
            queue_window(5'(w));
            first_blk = 31'(held_block[slot] - (held_block[slot] % w) + slot);
            if (first_blk <= held_block[slot]) first_blk = 31'(first_blk + w);
            queue_request(1'b0, first_blk, 5'($urandom));
            wait_drained();
            room = (TOP_BLOCK - first_blk) / w;
            if (ignored_total == fec_wt_pkg::CNT_MAX) begin
                steps = 3;
                wrap_next = 1;
            end else begin
                steps = longint'(fec_wt_pkg::CNT_MAX - ignored_total) + 1;
                if (steps > room) steps = room;
            end
            if (steps >= 2) begin
                queue_request(1'b0, 31'(first_blk + steps * w), 5'($urandom));
                wait_drained();
                if (wrap_next) ignored_wrapped = 1;
            end
        end
        queue_request(1'b0, TOP_BLOCK, 5'd31);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_reports.size());
            mismatches++;
        end

        $display("Run covered %0d requests and %0d window writes; %0d results checked.",
                 requests_sent, window_writes, reports_checked);
        $display("Stored %0d, closed %0d, stale %0d, duplicate %0d, cleared %0d; %s",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4],
                 ignored_wrapped ? "ignored counter restarted from its maximum."
                                 : "ignored counter did not reach its maximum.");
        if (mismatches == 0) begin
            $display("fec_receive_block_window_tracker_core: match");
        end else begin
            $display("fec_receive_block_window_tracker_core: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #1000000;
        $display("%0t: run timed out", $time);
        $display("fec_receive_block_window_tracker_core: mismatch");
        $finish;
    end

endmodule

[files.f]
hw/rtl/fec_wt_pkg.sv
hw/rtl/fec_wt_div.sv
hw/rtl/fec_wt_ctrl.sv
hw/rtl/fec_wt_dp.sv
hw/rtl/fec_receive_block_window_tracker_core.sv
hw/rtl/fec_wt_checker.sv
verif/fec_receive_block_window_tracker_core_test.sv
